// ===== hdl/lcc_pkg.sv =====
package lcc_pkg;

    localparam int KEY_W    = 24;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 6;

    localparam int CAPACITY_DEF    = 32;
    localparam int DATA_WIDTH_DEF  = 64;
    localparam int STAMP_WIDTH_DEF = 32;

    localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_READ   = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_VICTIM = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_PRESENT = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef struct packed {
        logic    done;
        logic    hit;
        t_status status;
    } t_result;

endpackage

// ===== hdl/lcc_entry_ram.sv =====
module lcc_entry_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lcc_ctrl.sv =====
module lcc_ctrl #(
    parameter int CAPACITY    = lcc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH  = lcc_pkg::DATA_WIDTH_DEF,
    parameter int STAMP_WIDTH = lcc_pkg::STAMP_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_start,
    output logic                                             o_busy,
    input  logic [lcc_pkg::OP_W-1:0]                         i_op,
    input  logic [lcc_pkg::KEY_W-1:0]                        i_key,
    input  logic [DATA_WIDTH-1:0]                            i_data,
    input  logic [$clog2(CAPACITY+1)-1:0]                    i_eff_cap,
    output lcc_pkg::t_result                                 o_res,
    output logic [DATA_WIDTH-1:0]                            o_data_out,
    output logic [lcc_pkg::KEY_W-1:0]                        o_victim_key,
    output logic [$clog2(CAPACITY+1)-1:0]                    o_occ_next,
    output logic                                             o_ram_we,
    output logic [$clog2(CAPACITY)-1:0]                      o_ram_waddr,
    output logic [1+lcc_pkg::KEY_W+STAMP_WIDTH+DATA_WIDTH-1:0] o_ram_wdata,
    output logic                                             o_ram_re,
    output logic [$clog2(CAPACITY)-1:0]                      o_ram_raddr,
    input  logic [1+lcc_pkg::KEY_W+STAMP_WIDTH+DATA_WIDTH-1:0] i_ram_rdata
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W  = lcc_pkg::KEY_W;
    localparam int WORD_W = 1 + KEY_W + STAMP_WIDTH + DATA_WIDTH;
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [lcc_pkg::OP_W-1:0] r_op, n_op;
    logic [KEY_W-1:0]         r_key, n_key;
    logic [DATA_WIDTH-1:0]    r_din, n_din;
    logic [ADDR_W-1:0]        r_idx, n_idx;
    logic                     r_match_found, n_match_found;
    logic [ADDR_W-1:0]        r_match_idx, n_match_idx;
    logic [DATA_WIDTH-1:0]    r_match_data, n_match_data;
    logic                     r_free_found, n_free_found;
    logic [ADDR_W-1:0]        r_free_idx, n_free_idx;
    logic                     r_best_found, n_best_found;
    logic [STAMP_WIDTH-1:0]   r_best_stamp, n_best_stamp;
    logic [KEY_W-1:0]         r_best_key, n_best_key;
    logic [STAMP_WIDTH-1:0]   r_seq, n_seq;
    logic [OCC_W-1:0]         r_occ, n_occ;

    logic                   w_e_valid;
    logic [KEY_W-1:0]       w_e_key;
    logic [STAMP_WIDTH-1:0] w_e_stamp;
    logic [DATA_WIDTH-1:0]  w_e_data;

    assign w_e_valid = i_ram_rdata[WORD_W-1];
    assign w_e_key   = i_ram_rdata[WORD_W-2 -: KEY_W];
    assign w_e_stamp = i_ram_rdata[STAMP_WIDTH+DATA_WIDTH-1 : DATA_WIDTH];
    assign w_e_data  = i_ram_rdata[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_seq   <= '0;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_seq   <= n_seq;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_key         <= n_key;
        r_din         <= n_din;
        r_match_found <= n_match_found;
        r_match_idx   <= n_match_idx;
        r_match_data  <= n_match_data;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_best_found  <= n_best_found;
        r_best_stamp  <= n_best_stamp;
        r_best_key    <= n_best_key;
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_key         = r_key;
        n_din         = r_din;
        n_idx         = r_idx;
        n_match_found = r_match_found;
        n_match_idx   = r_match_idx;
        n_match_data  = r_match_data;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_best_found  = r_best_found;
        n_best_stamp  = r_best_stamp;
        n_best_key    = r_best_key;
        n_seq         = r_seq;
        n_occ         = r_occ;
        o_ram_we      = 1'b0;
        o_ram_waddr   = r_idx;
        o_ram_wdata   = '0;
        o_ram_re      = 1'b0;
        o_ram_raddr   = '0;
        o_res         = '0;
        o_data_out    = '0;
        o_victim_key  = '0;

        case (r_state)
            S_CLEAR: begin
                o_ram_we = 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op          = i_op;
                    n_key         = i_key;
                    n_din         = i_data;
                    n_idx         = '0;
                    n_match_found = 1'b0;
                    n_free_found  = 1'b0;
                    n_best_found  = 1'b0;
                    o_ram_re      = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_e_valid && (w_e_key == r_key) && !r_match_found) begin
                    n_match_found = 1'b1;
                    n_match_idx   = r_idx;
                    n_match_data  = w_e_data;
                end
                if (!w_e_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                if (w_e_valid && (!r_best_found || (w_e_stamp < r_best_stamp))) begin
                    n_best_found = 1'b1;
                    n_best_stamp = w_e_stamp;
                    n_best_key   = w_e_key;
                end
                if (r_idx == LAST) begin
                    n_state = S_WRITE;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_idx + ADDR_W'(1);
                    n_idx       = r_idx + ADDR_W'(1);
                end
            end
            S_WRITE: begin
                o_res.done = 1'b1;
                n_state    = S_IDLE;
                case (r_op)
                    lcc_pkg::OP_LOOKUP: begin
                        if (r_match_found) begin
                            o_res.hit   = 1'b1;
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_match_idx;
                            o_ram_wdata = {1'b1, r_key, r_seq, r_match_data};
                            n_seq       = r_seq + STAMP_WIDTH'(1);
                        end else begin
                            o_res.status = lcc_pkg::ST_ABSENT;
                        end
                    end
                    lcc_pkg::OP_READ: begin
                        if (r_match_found) begin
                            o_res.hit  = 1'b1;
                            o_data_out = r_match_data;
                        end else begin
                            o_res.status = lcc_pkg::ST_ABSENT;
                        end
                    end
                    lcc_pkg::OP_INSERT: begin
                        if (r_match_found) begin
                            o_res.hit    = 1'b1;
                            o_res.status = lcc_pkg::ST_PRESENT;
                        end else if ((r_occ >= i_eff_cap) || !r_free_found) begin
                            o_res.status = lcc_pkg::ST_FULL;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_free_idx;
                            o_ram_wdata = {1'b1, r_key, r_seq, r_din};
                            n_seq       = r_seq + STAMP_WIDTH'(1);
                            n_occ       = r_occ + OCC_W'(1);
                        end
                    end
                    lcc_pkg::OP_REMOVE: begin
                        if (r_match_found) begin
                            o_res.hit   = 1'b1;
                            o_data_out  = r_match_data;
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_match_idx;
                            o_ram_wdata = '0;
                            if (r_occ != '0) begin
                                n_occ = r_occ - OCC_W'(1);
                            end
                        end else begin
                            o_res.status = lcc_pkg::ST_ABSENT;
                        end
                    end
                    lcc_pkg::OP_VICTIM: begin
                        if (r_best_found) begin
                            o_victim_key = r_best_key;
                        end else begin
                            o_res.status = lcc_pkg::ST_EMPTY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_occ_next = n_occ;

endmodule

// ===== hdl/lru_context_cache_table.sv =====
// Fully associative LRU cache of keyed context entries, all held in one
// single-port-read, single-port-write entry memory. Pulse start while busy is
// low to issue an operation; every operation walks all CAPACITY entries, one
// memory read per cycle, then does the write-back in the S_WRITE state, and
// busy stays high through the scan and the write-back, so a new operation
// can be issued only once the last one is through. The single result is
// registered from the write-back state and shown on the result ports for
// exactly one cycle while o_result_valid is high, and is taken at the edge at
// which the next operation can first be accepted; it cannot be held off. After
// reset the block sweeps all CAPACITY entries of the memory to clear them and
// keeps busy high meanwhile. Write capacity_in_use through the config channel
// only while idle.
module lru_context_cache_table #(
    parameter int CAPACITY    = lcc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH  = lcc_pkg::DATA_WIDTH_DEF,
    parameter int STAMP_WIDTH = lcc_pkg::STAMP_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lcc_pkg::OP_W-1:0]     i_operation,
    input  logic [lcc_pkg::KEY_W-1:0]    i_resource_key,
    input  logic [DATA_WIDTH-1:0]        i_data_in,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lcc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_result_valid,
    output logic                         o_hit,
    output logic [DATA_WIDTH-1:0]        o_data_out,
    output logic [lcc_pkg::KEY_W-1:0]    o_victim_key,
    output logic                         o_is_full,
    output logic [lcc_pkg::STATUS_W-1:0] o_status
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int CFG_W  = lcc_pkg::CFG_W;
    localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int WORD_W = 1 + lcc_pkg::KEY_W + STAMP_WIDTH + DATA_WIDTH;

    logic [CFG_W-1:0]            r_cap;
    logic [CMP_W-1:0]            w_cap_ext;
    logic [CMP_W-1:0]            w_eff;
    logic [OCC_W-1:0]            w_eff_cap;
    lcc_pkg::t_result            w_res;
    logic [DATA_WIDTH-1:0]       w_data_out;
    logic [lcc_pkg::KEY_W-1:0]   w_victim_key;
    logic [OCC_W-1:0]            w_occ_next;
    logic                        w_ram_we;
    logic [ADDR_W-1:0]           w_ram_waddr;
    logic [WORD_W-1:0]           w_ram_wdata;
    logic                        w_ram_re;
    logic [ADDR_W-1:0]           w_ram_raddr;
    logic [WORD_W-1:0]           w_ram_rdata;

    logic                        r_result_valid;
    logic                        r_hit;
    logic [DATA_WIDTH-1:0]       r_data_out;
    logic [lcc_pkg::KEY_W-1:0]   r_victim_key;
    logic                        r_is_full;
    logic [lcc_pkg::STATUS_W-1:0] r_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lcc_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // clamp capacity to the range 1 .. CAPACITY
    assign w_cap_ext = CMP_W'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(CAPACITY)) begin
            w_eff = CMP_W'(CAPACITY);
        end else begin
            w_eff = w_cap_ext;
        end
    end
    assign w_eff_cap = w_eff[OCC_W-1:0];

    lcc_entry_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    lcc_ctrl #(
        .CAPACITY    (CAPACITY),
        .DATA_WIDTH  (DATA_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_op         (i_operation),
        .i_key        (i_resource_key),
        .i_data       (i_data_in),
        .i_eff_cap    (w_eff_cap),
        .o_res        (w_res),
        .o_data_out   (w_data_out),
        .o_victim_key (w_victim_key),
        .o_occ_next   (w_occ_next),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.done) begin
            r_hit        <= w_res.hit;
            r_data_out   <= w_data_out;
            r_victim_key <= w_victim_key;
            r_is_full    <= (w_occ_next >= w_eff_cap);
            r_status     <= w_res.status;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_hit          = r_hit;
    assign o_data_out     = r_data_out;
    assign o_victim_key   = r_victim_key;
    assign o_is_full      = r_is_full;
    assign o_status       = r_status;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted operation did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy || $past(start && !busy)) && !$past(o_result_valid))
        else $error("result strobe overlaps operation or repeats");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (w_occ_next <= OCC_W'(CAPACITY)))
        else $error("occupancy exceeds capacity");

endmodule

// ===== dv/tb_lru_context_cache_table.sv =====
`timescale 1ns / 100ps

module tb_lru_context_cache_table;

    import lcc_pkg::*;

    localparam int SLOTS       = CAPACITY_DEF;
    localparam int DATA_W      = DATA_WIDTH_DEF;
    localparam int STAMP_W     = STAMP_WIDTH_DEF;
    localparam int KEY_POOL    = 48;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 160;
    localparam int DRAIN_LIMIT = 4000;

    typedef struct {
        bit                hit;
        bit [DATA_W-1:0]   data;
        bit [KEY_W-1:0]    victim;
        bit                full;
        t_status           status;
    } t_cache_resp;

    class cache_scoreboard;
        bit                slot_valid[SLOTS];
        bit [KEY_W-1:0]    slot_key[SLOTS];
        bit [DATA_W-1:0]   slot_data[SLOTS];
        bit [STAMP_W-1:0]  slot_stamp[SLOTS];
        bit [STAMP_W-1:0]  seq_count;
        int unsigned       occupied;
        bit [CFG_W-1:0]    capacity;
        t_cache_resp       expected_q[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       noted;
        int unsigned       hits;
        int unsigned       absent;
        int unsigned       refused_full;
        int unsigned       empty_picks;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            seq_count = '0;
            occupied  = 0;
            capacity  = CAP_RESET;
        endfunction

        function int unsigned eff_capacity();
            if (capacity == '0) return 1;
            if (capacity > SLOTS) return SLOTS;
            return capacity;
        endfunction

        function int find_key(bit [KEY_W-1:0] key);
            foreach (slot_valid[i])
                if (slot_valid[i] && slot_key[i] == key) return i;
            return -1;
        endfunction

        function int find_free();
            foreach (slot_valid[i])
                if (!slot_valid[i]) return i;
            return -1;
        endfunction

        function void set_capacity(bit [CFG_W-1:0] value);
            capacity = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function bit [KEY_W-1:0] present_key();
            int live[$];
            foreach (slot_valid[i])
                if (slot_valid[i]) live.push_back(i);
            if (live.size() == 0) return KEY_W'($urandom());
            return slot_key[live[$urandom_range(0, live.size() - 1)]];
        endfunction

        function void note_item(t_op op, bit [KEY_W-1:0] key, bit [DATA_W-1:0] data);
            t_cache_resp r;
            int          s;
            int          best;
            r.hit    = 1'b0;
            r.data   = '0;
            r.victim = '0;
            r.status = ST_OK;
            case (op)
                OP_LOOKUP: begin
                    s = find_key(key);
                    if (s >= 0) begin
                        r.hit         = 1'b1;
                        slot_stamp[s] = seq_count;
                        seq_count     = seq_count + 1'b1;
                    end else begin
                        r.status = ST_ABSENT;
                    end
                end
                OP_READ: begin
                    s = find_key(key);
                    if (s >= 0) begin
                        r.hit  = 1'b1;
                        r.data = slot_data[s];
                    end else begin
                        r.status = ST_ABSENT;
                    end
                end
                OP_INSERT: begin
                    s = find_key(key);
                    if (s >= 0) begin
                        r.hit    = 1'b1;
                        r.status = ST_PRESENT;
                    end else if (occupied >= eff_capacity()) begin
                        r.status = ST_FULL;
                    end else begin
                        s = find_free();
                        if (s < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            slot_valid[s] = 1'b1;
                            slot_key[s]   = key;
                            slot_data[s]  = data;
                            slot_stamp[s] = seq_count;
                            seq_count     = seq_count + 1'b1;
                            occupied++;
                        end
                    end
                end
                OP_REMOVE: begin
                    s = find_key(key);
                    if (s >= 0) begin
                        r.hit         = 1'b1;
                        r.data        = slot_data[s];
                        slot_valid[s] = 1'b0;
                        if (occupied > 0) occupied--;
                    end else begin
                        r.status = ST_ABSENT;
                    end
                end
                OP_VICTIM: begin
                    best = -1;
                    foreach (slot_valid[i])
                        if (slot_valid[i] && (best < 0 || slot_stamp[i] < slot_stamp[best]))
                            best = i;
                    if (best >= 0) r.victim = slot_key[best];
                    else r.status = ST_EMPTY;
                end
                default: ;
            endcase
            r.full = (occupied >= eff_capacity());
            noted++;
            if (r.hit) hits++;
            if (r.status == ST_ABSENT) absent++;
            if (r.status == ST_FULL) refused_full++;
            if (r.status == ST_EMPTY) empty_picks++;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 30) $display("ERROR: %s", what);
        endtask

        task check_result(logic hit, logic [DATA_W-1:0] data, logic [KEY_W-1:0] victim,
                          logic full, logic [STATUS_W-1:0] status);
            t_cache_resp e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with none outstanding, status %0d", status));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (hit !== e.hit || data !== e.data || victim !== e.victim ||
                full !== e.full || status !== e.status)
                report_mismatch($sformatf(
                    "result %0d: hit %b data %h victim %h full %b status %0d, want %b %h %h %b %0d",
                    checked, hit, data, victim, full, status,
                    e.hit, e.data, e.victim, e.full, e.status));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_operation = '0;
    logic [KEY_W-1:0]      i_resource_key = '0;
    logic [DATA_W-1:0]     i_data_in = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  o_result_valid;
    logic                  o_hit;
    logic [DATA_W-1:0]     o_data_out;
    logic [KEY_W-1:0]      o_victim_key;
    logic                  o_is_full;
    logic [STATUS_W-1:0]   o_status;

    cache_scoreboard       sb;
    bit [KEY_W-1:0]        key_pool[KEY_POOL];
    int unsigned           cap_writes;

    lru_context_cache_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_resource_key (i_resource_key),
        .i_data_in      (i_data_in),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_data_out     (o_data_out),
        .o_victim_key   (o_victim_key),
        .o_is_full      (o_is_full),
        .o_status       (o_status)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            sb.check_result(o_hit, o_data_out, o_victim_key, o_is_full, o_status);
    end

    initial begin
        #(10_000_000);
        $display("lru_context_cache_table: mismatch");
        $finish;
    end

    task send_item(t_op op, bit [KEY_W-1:0] key, bit [DATA_W-1:0] data, int unsigned gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_operation    <= op;
        i_resource_key <= key;
        i_data_in      <= data;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(op, key, data);
    endtask

    task hold_sender();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task drain();
        int unsigned waited;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task write_capacity(bit [CFG_W-1:0] value);
        hold_sender();
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_capacity(value);
        cap_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit [KEY_W-1:0] pick_key(int unsigned npool);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return key_pool[$urandom_range(0, npool - 1)];
        if (r < 85) return sb.present_key();
        return KEY_W'($urandom());
    endfunction

    function automatic t_op pick_op(int unsigned ins_w, int unsigned rem_w);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < ins_w) return OP_INSERT;
        if (r < ins_w + rem_w) return OP_REMOVE;
        r = $urandom_range(0, 99);
        if (r < 40) return OP_LOOKUP;
        if (r < 65) return OP_READ;
        if (r < 93) return OP_VICTIM;
        return t_op'($urandom_range(int'(OP_VICTIM) + 1, (1 << OP_W) - 1));
    endfunction

    initial begin
        bit [CFG_W-1:0]  cap_plan[PHASES];
        bit [KEY_W-1:0]  key_max;
        bit [DATA_W-1:0] data_max;
        int unsigned     npool;
        int unsigned     ins_w;
        int unsigned     rem_w;
        bit              no_gaps;

        sb         = new();
        cap_writes = 0;
        key_max    = '1;
        data_max   = '1;
        cap_plan   = '{6'd32, 6'd63, 6'd2, 6'd0, 6'd17, 6'd32, 6'd1, 6'd9, 6'd40, 6'd0};
        cap_plan[PHASES-1] = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom());

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_VICTIM, '0, '0, 0);
        send_item(OP_LOOKUP, '0, '0, 1);
        send_item(OP_REMOVE, key_max, '0, 0);
        send_item(OP_READ, key_max, '0, 3);
        send_item(OP_INSERT, '0, '0, 0);
        send_item(OP_INSERT, key_max, data_max, 0);
        send_item(OP_INSERT, key_max, '0, 2);
        send_item(OP_LOOKUP, '0, data_max, 0);
        send_item(OP_VICTIM, key_max, '0, 0);
        send_item(OP_READ, key_max, '0, 5);
        send_item(OP_READ, '0, '0, 0);
        for (int c = int'(OP_VICTIM) + 1; c < (1 << OP_W); c++)
            send_item(t_op'(c), key_max, data_max, 0);
        send_item(OP_REMOVE, '0, '0, 11);
        send_item(OP_VICTIM, '0, '0, 0);

        write_capacity('0);
        send_item(OP_INSERT, 24'h5a5a5a, 64'ha5a5_a5a5_a5a5_a5a5, 0);
        send_item(OP_REMOVE, key_max, '0, 0);
        send_item(OP_INSERT, 24'h5a5a5a, 64'ha5a5_a5a5_a5a5_a5a5, 4);
        send_item(OP_INSERT, 24'ha5a5a5, 64'h5a5a_5a5a_5a5a_5a5a, 0);
        send_item(OP_VICTIM, '0, '0, 0);

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(cap_plan[p]);
            npool   = sb.eff_capacity() + $urandom_range(1, 10);
            if (npool > KEY_POOL) npool = KEY_POOL;
            ins_w   = (p == 0) ? 55 : $urandom_range(20, 45);
            rem_w   = (p == 0) ? 8 : $urandom_range(10, 30);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    hold_sender();
                    drain();
                end
                send_item(pick_op(ins_w, rem_w), pick_key(npool),
                          {$urandom(), $urandom()}, no_gaps ? 0 : $urandom_range(0, 11));
            end
        end

        hold_sender();
        drain();
        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d operations over %0d capacity writes, %0d results checked",
                 sb.noted, cap_writes, sb.checked);
        $display("%0d hits, %0d absent keys, %0d inserts refused as full, %0d empty victim picks",
                 sb.hits, sb.absent, sb.refused_full, sb.empty_picks);
        if (sb.mismatches == 0)
            $display("lru_context_cache_table: match");
        else
            $display("lru_context_cache_table: mismatch");
        $finish;
    end

endmodule
